>>> rtl/core/lmi_pkg.sv
// Shared constants for the LU matrix inverse block.
`default_nettype none
package lmi_pkg;
  localparam int MAX_DIM_DEF = 8;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int DIM_W       = 4;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam logic [DIM_W-1:0]  DIM_RESET = 4'd4;
  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [0:0]        REG_DIM   = 1'b0;
endpackage
`default_nettype wire

>>> rtl/core/lmi_div.sv
// Iterative signed Q16.16 divider with saturation, one quotient bit per cycle.
`default_nettype none
module lmi_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lmi_pkg::DATA_W-1:0] num,
  input  wire logic [lmi_pkg::DATA_W-1:0] den,
  output logic                            done,
  output logic [lmi_pkg::DATA_W-1:0]      quo
);
  import lmi_pkg::*;

  localparam int QW = DATA_W + 16;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);
  localparam logic [QW-1:0] POS_MAX = QW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [QW-1:0] NEG_MAX = QW'({1'b1, {(DATA_W-1){1'b0}}});

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W:0]   rem_r;
  logic [QW-1:0]     dvd_r;
  logic [QW-1:0]     q_r;
  logic [DATA_W-1:0] dbs_r;
  logic              neg_r;
  logic              done_r;
  logic [DATA_W-1:0] res_r;

  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [QW-1:0]     q_fin;
  logic [DATA_W-1:0] res_nxt;

  assign num_mag = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[DATA_W-1] ? (~den + 1'b1) : den;
  assign rem_sh  = {rem_r[DATA_W-1:0], dvd_r[QW-1]};
  assign ge      = rem_sh >= {1'b0, dbs_r};
  assign q_fin   = {q_r[QW-2:0], ge};

  always_comb begin
    if (neg_r) begin
      if (q_fin > NEG_MAX) begin
        res_nxt = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        res_nxt = DATA_W'(~q_fin + 1'b1);
      end
    end else begin
      if (q_fin > POS_MAX) begin
        res_nxt = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        res_nxt = q_fin[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == '0) begin
          done_r <= 1'b1;
          if (num == '0) begin
            res_r <= '0;
          end else if (num[DATA_W-1]) begin
            res_r <= {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            res_r <= {1'b0, {(DATA_W-1){1'b1}}};
          end
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= '0;
          dvd_r  <= {num_mag, 16'b0};
          q_r    <= '0;
          dbs_r  <= den_mag;
          neg_r  <= num[DATA_W-1] ^ den[DATA_W-1];
        end
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, dbs_r}) : rem_sh;
        dvd_r <= {dvd_r[QW-2:0], 1'b0};
        q_r   <= q_fin;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= res_nxt;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = res_r;
endmodule
`default_nettype wire

>>> rtl/core/lu_matrix_inverse.sv
// Top level of the LU matrix inverse: matrix memory, sequencer, MAC pipeline and output.
`default_nettype none
// Loads an n-by-n signed Q16.16 matrix one element per cycle, row-major, then inverts it
// in place (Crout LU without pivoting, inverse of L and U, product) and sends the inverse
// out row-major with out_last on the final element. No input is taken from the transfer
// that completes the matrix until the final result is taken. Compute time is set by the
// dual-read matrix memory feeding one multiply-accumulate per cycle, the sequencing steps
// of each computed element (184 elements for n = 8), and the serial divider with n^2
// quotients; output reads, registers and holds each element while out_ready is low, and
// moves on to the next element only once it is taken.
module lu_matrix_inverse #(
  parameter int MAX_DIM = lmi_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lmi_pkg::DATA_W-1:0] in_element,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lmi_pkg::DATA_W-1:0]      out_result,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmi_pkg::CFG_AW-1:0] paddr,
  input  wire logic [lmi_pkg::CFG_DW-1:0] pwdata,
  output logic [lmi_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready
);
  import lmi_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IW    = $clog2(MAX_DIM + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int TW    = 2 * IW + 1;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b0000_0000_0001,
    S_JOB   = 12'b0000_0000_0010,
    S_MAC   = 12'b0000_0000_0100,
    S_FRD   = 12'b0000_0000_1000,
    S_FCALC = 12'b0000_0001_0000,
    S_FRND  = 12'b0000_0010_0000,
    S_FSEL  = 12'b0000_0100_0000,
    S_FDIV  = 12'b0000_1000_0000,
    S_FWR   = 12'b0001_0000_0000,
    S_ORD   = 12'b0010_0000_0000,
    S_OLD   = 12'b0100_0000_0000,
    S_OWT   = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [5:0] {
    PH_DIV0 = 6'b00_0001,
    PH_LCOL = 6'b00_0010,
    PH_UROW = 6'b00_0100,
    PH_LINV = 6'b00_1000,
    PH_UINV = 6'b01_0000,
    PH_PROD = 6'b10_0000
  } phase_t;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                          input logic [IW-1:0] nn);
    logic [TW-1:0] t;
    t = TW'(r) * TW'(nn) + TW'(c);
    return t[AW-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat64(input logic [ACC_W:0] x);
    if (x[ACC_W] != x[ACC_W-1]) begin
      return x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return x[ACC_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];

  state_t            state_r;
  phase_t            ph_r;
  logic [DIM_W-1:0]  dim_r;
  logic [CW-1:0]     lc_r;
  logic [IW-1:0]     row_r, col_r;
  logic [IW-1:0]     i_r, j_r, k_r, kend_r;
  logic [AW-1:0]     oidx_r;
  logic              p1_r, p2_r, one_p1_r;
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic [ACC_W-1:0]  prod_r, acc_r, v_r;
  logic [DATA_W-1:0] raw_r, den_r, q_r, wdata_r;
  logic              out_valid_r, out_last_r;
  logic [DATA_W-1:0] out_result_r;

  logic [IW-1:0]     n;
  logic [CW-1:0]     total;
  logic              cfg_wr;
  logic              in_fire;
  logic [AW-1:0]     ra_addr, rb_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              issue;
  logic              one_k;
  logic [IW-1:0]     mrow, mcol;
  logic [AW-1:0]     tgt_addr, den_addr;
  logic [IW-1:0]     kstart, kend;
  logic [DATA_W-1:0] opa;
  logic [ACC_W-1:0]  base;
  logic [ACC_W:0]    rnd;
  logic [ACC_W-16:0] rq;
  logic [DATA_W-1:0] q_nxt;
  logic              need_div;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_num, div_quo;
  logic [IW:0]       i_p1, i_p2, j_p1;

  always_comb begin
    if (dim_r == '0) begin
      n = IW'(1);
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      n = IW'(MAX_DIM);
    end else begin
      n = dim_r[IW-1:0];
    end
  end

  assign total   = CW'(CW'(n) * CW'(n));
  assign cfg_wr  = psel & penable & pwrite;
  assign in_fire = in_valid & in_ready;
  assign i_p1    = {1'b0, i_r} + 1'b1;
  assign i_p2    = {1'b0, i_r} + 2'd2;
  assign j_p1    = {1'b0, j_r} + 1'b1;

  assign issue = k_r < kend_r;
  assign mrow  = ((ph_r == PH_UROW) || (ph_r == PH_UINV)) ? i_r : j_r;
  assign mcol  = ((ph_r == PH_UROW) || (ph_r == PH_UINV)) ? j_r : i_r;

  always_comb begin
    unique case (ph_r)
      PH_DIV0: tgt_addr = maddr('0, i_r, n);
      PH_UROW, PH_UINV: tgt_addr = maddr(i_r, j_r, n);
      default: tgt_addr = maddr(j_r, i_r, n);
    endcase
    unique case (ph_r)
      PH_DIV0: den_addr = maddr('0, '0, n);
      PH_UROW: den_addr = maddr(i_r, i_r, n);
      default: den_addr = maddr(j_r, j_r, n);
    endcase
    unique case (ph_r)
      PH_LCOL, PH_UROW: begin
        kstart = '0;
        kend   = i_r;
      end
      PH_LINV, PH_UINV: begin
        kstart = i_r;
        kend   = j_r;
      end
      PH_PROD: begin
        kstart = (i_r > j_r) ? i_r : j_r;
        kend   = n;
      end
      default: begin
        kstart = '0;
        kend   = '0;
      end
    endcase
  end

  always_comb begin
    ra_addr = '0;
    rb_addr = '0;
    unique case (state_r)
      S_MAC: begin
        ra_addr = maddr(mrow, k_r, n);
        rb_addr = maddr(k_r, mcol, n);
      end
      S_FRD: begin
        ra_addr = tgt_addr;
        rb_addr = den_addr;
      end
      S_ORD: ra_addr = oidx_r;
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = tgt_addr;
    wdata = wdata_r;
    if (in_fire) begin
      we    = 1'b1;
      waddr = lc_r[AW-1:0];
      wdata = ((row_r == col_r) && (in_element == '0)) ? DATA_W'(1) : in_element;
    end else if (state_r == S_FWR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[ra_addr];
    rd_b_r <= mem[rb_addr];
  end

  assign one_k = ((ph_r == PH_UINV) && (i_r == k_r)) || ((ph_r == PH_PROD) && (j_r == k_r));
  assign opa   = one_p1_r ? Q_ONE : rd_a_r;
  assign base  = {{16{rd_a_r[DATA_W-1]}}, rd_a_r, 16'b0};
  assign rnd   = {v_r[ACC_W-1], v_r} + (ACC_W+1)'(32768);
  assign rq    = rnd[ACC_W:16];

  always_comb begin
    if (rq[ACC_W-16] && !(&rq[ACC_W-16:DATA_W-1])) begin
      q_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!rq[ACC_W-16] && (|rq[ACC_W-16:DATA_W-1])) begin
      q_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      q_nxt = rq[DATA_W-1:0];
    end
  end

  assign need_div  = (ph_r == PH_DIV0) || (ph_r == PH_UROW) || (ph_r == PH_LINV);
  assign div_start = (state_r == S_FSEL) && need_div;
  always_comb begin
    if (ph_r == PH_DIV0) begin
      div_num = raw_r;
    end else if ((ph_r == PH_LINV) && (i_r == j_r)) begin
      div_num = Q_ONE;
    end else begin
      div_num = q_r;
    end
  end

  lmi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ph_r        <= PH_DIV0;
      dim_r       <= DIM_RESET;
      lc_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kend_r      <= '0;
      oidx_r      <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (cfg_wr && (paddr[CFG_AW-1:2] == REG_DIM)) begin
        dim_r <= pwdata[DIM_W-1:0];
        lc_r  <= '0;
        row_r <= '0;
        col_r <= '0;
      end else if (in_fire) begin
        if (lc_r + 1'b1 == total) begin
          lc_r   <= '0;
          row_r  <= '0;
          col_r  <= '0;
          oidx_r <= '0;
          ph_r   <= PH_DIV0;
          i_r    <= IW'(1);
          j_r    <= '0;
          state_r <= (n == IW'(1)) ? S_ORD : S_JOB;
        end else begin
          lc_r <= lc_r + 1'b1;
          if (col_r + 1'b1 == n) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end

      unique case (state_r)
        S_LOAD: ;
        S_JOB: begin
          k_r     <= kstart;
          kend_r  <= kend;
          acc_r   <= '0;
          p1_r    <= 1'b0;
          p2_r    <= 1'b0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          p1_r     <= issue;
          one_p1_r <= one_k;
          p2_r     <= p1_r;
          if (issue) begin
            k_r <= k_r + 1'b1;
          end
          if (p1_r) begin
            prod_r <= ACC_W'($signed(opa) * $signed(rd_b_r));
          end
          if (p2_r) begin
            if (ph_r == PH_LINV) begin
              acc_r <= sat64({acc_r[ACC_W-1], acc_r} - {prod_r[ACC_W-1], prod_r});
            end else begin
              acc_r <= sat64({acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r});
            end
          end
          if (!issue && !p1_r && !p2_r) begin
            state_r <= S_FRD;
          end
        end
        S_FRD: state_r <= S_FCALC;
        S_FCALC: begin
          raw_r <= rd_a_r;
          den_r <= rd_b_r;
          if ((ph_r == PH_LCOL) || (ph_r == PH_UROW)) begin
            v_r <= sat64({base[ACC_W-1], base} - {acc_r[ACC_W-1], acc_r});
          end else if (ph_r == PH_UINV) begin
            v_r <= sat64('0 - {acc_r[ACC_W-1], acc_r});
          end else begin
            v_r <= acc_r;
          end
          state_r <= S_FRND;
        end
        S_FRND: begin
          q_r     <= q_nxt;
          state_r <= S_FSEL;
        end
        S_FSEL: begin
          wdata_r <= q_r;
          state_r <= need_div ? S_FDIV : S_FWR;
        end
        S_FDIV: begin
          if (div_done) begin
            wdata_r <= div_quo;
            state_r <= S_FWR;
          end
        end
        S_FWR: begin
          state_r <= S_JOB;
          unique case (ph_r)
            PH_DIV0: begin
              if (i_p1 == {1'b0, n}) begin
                ph_r <= PH_LCOL;
                i_r  <= IW'(1);
                j_r  <= IW'(1);
              end else begin
                i_r <= i_r + 1'b1;
              end
            end
            PH_LCOL: begin
              if (j_p1 == {1'b0, n}) begin
                if (i_p1 == {1'b0, n}) begin
                  ph_r <= PH_LINV;
                  i_r  <= '0;
                  j_r  <= '0;
                end else begin
                  ph_r <= PH_UROW;
                  j_r  <= i_r + 1'b1;
                end
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
            PH_UROW: begin
              if (j_p1 == {1'b0, n}) begin
                ph_r <= PH_LCOL;
                i_r  <= i_r + 1'b1;
                j_r  <= i_r + 1'b1;
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
            PH_LINV: begin
              if (j_p1 == {1'b0, n}) begin
                if (i_p1 == {1'b0, n}) begin
                  ph_r <= PH_UINV;
                  i_r  <= '0;
                  j_r  <= IW'(1);
                end else begin
                  i_r <= i_r + 1'b1;
                  j_r <= i_r + 1'b1;
                end
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
            PH_UINV: begin
              if (j_p1 == {1'b0, n}) begin
                if (i_p2 >= {1'b0, n}) begin
                  ph_r <= PH_PROD;
                  i_r  <= '0;
                  j_r  <= '0;
                end else begin
                  i_r <= i_r + 1'b1;
                  j_r <= i_p2[IW-1:0];
                end
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
            PH_PROD: begin
              if (j_p1 == {1'b0, n}) begin
                j_r <= '0;
                if (i_p1 == {1'b0, n}) begin
                  state_r <= S_ORD;
                end else begin
                  i_r <= i_r + 1'b1;
                end
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          out_result_r <= rd_a_r;
          out_last_r   <= (CW'(oidx_r) + 1'b1) == total;
          out_valid_r  <= 1'b1;
          state_r      <= S_OWT;
        end
        S_OWT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_LOAD;
            end else begin
              oidx_r  <= oidx_r + 1'b1;
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_ready   = (state_r == S_LOAD);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_last   = out_last_r;
  assign pready     = 1'b1;
  assign prdata     = (paddr[CFG_AW-1:2] == REG_DIM) ? CFG_DW'(dim_r) : '0;
endmodule
`default_nettype wire
